// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property with asynchronous active-low reset masking.
`define TEPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// A stalled transfer keeps valid high and its data unchanged.
`define TEPQ_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, dat, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && !rdy) |=> (vld && $stable(dat))) \
		else $error(msg);

`endif

// ----- rtl/core/tepq_pkg.sv -----
// Types and constants of the timed event priority queue.
package tepq_pkg;

	localparam int TIME_W     = 32;
	localparam int PRIO_W     = 16;
	localparam int ACT_W      = 4;
	localparam int PAY_W      = 32;
	localparam int STS_W      = 3;
	localparam int OP_W       = 2;
	localparam int S_DATA_W   = 88;
	localparam int M_DATA_W   = 88;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_TIME_LIMIT = '0;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK        = 3'd0,
		STS_EMPTY     = 3'd1,
		STS_LIMIT     = 3'd2,
		STS_FULL      = 3'd3,
		STS_PAST      = 3'd4,
		STS_NOT_FOUND = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_PUSH_SCAN,
		S_PUSH_INS,
		S_REM,
		S_FIN
	} state_t;

	typedef struct packed {
		logic ahead;      // stored entry stays ahead of the key
		logic act_match;  // stored action code equals the key's
	} cmp_res_t;

endpackage

// ----- rtl/core/tepq_mem.sv -----
// Entry store: one write port, one read port with registered read data.
module tepq_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 84,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/core/tepq_cmp.sv -----
// Shared order and action compare between a stored entry and the current key.
module tepq_cmp
	import tepq_pkg::*;
(
	input  logic        [TIME_W-1:0] ent_time,
	input  logic signed [PRIO_W-1:0] ent_prio,
	input  logic        [ACT_W-1:0]  ent_act,
	input  logic        [TIME_W-1:0] key_time,
	input  logic signed [PRIO_W-1:0] key_prio,
	input  logic        [ACT_W-1:0]  key_act,
	output cmp_res_t                 res
);

	always_comb begin
		// equal time falls back to priority; equal priority keeps arrival order
		if (ent_time != key_time) begin
			res.ahead = ent_time < key_time;
		end else begin
			res.ahead = ent_prio >= key_prio;
		end
		res.act_match = ent_act == key_act;
	end

endmodule

// ----- rtl/core/tepq_ctrl.sv -----
// Sequencer: walks the sorted store one entry per cycle for insert and remove.
module tepq_ctrl
	import tepq_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int PAYLOAD_BITS = 32,
	localparam int AW = $clog2(DEPTH),
	localparam int EW = TIME_W + PRIO_W + ACT_W + PAYLOAD_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  op_t                      in_op,
	input  logic        [TIME_W-1:0] in_time,
	input  logic signed [PRIO_W-1:0] in_prio,
	input  logic        [ACT_W-1:0]  in_act,
	input  logic        [PAY_W-1:0]  in_payload,
	input  logic        [TIME_W-1:0] time_limit,
	output logic                     out_valid,
	input  logic                     out_ready,
	output status_t                  out_status,
	output logic        [TIME_W-1:0] out_time,
	output logic signed [PRIO_W-1:0] out_prio,
	output logic        [ACT_W-1:0]  out_act,
	output logic        [PAY_W-1:0]  out_payload,
	output logic                     mem_wr_en,
	output logic        [AW-1:0]     mem_wr_addr,
	output logic        [EW-1:0]     mem_wr_data,
	output logic        [AW-1:0]     mem_rd_addr,
	input  logic        [EW-1:0]     mem_rd_data
);

	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	op_t                      op_q;
	logic        [TIME_W-1:0] time_in_q;
	logic signed [PRIO_W-1:0] prio_in_q;
	logic        [ACT_W-1:0]  act_in_q;
	logic [PAYLOAD_BITS-1:0]  pay_in_q;
	logic [EW-1:0]            head_q;
	logic [AW-1:0]            idx_q;
	logic [CW-1:0]            count_q;
	logic [TIME_W-1:0]        cur_time_q;
	logic                     found_q;
	status_t                  sts_q;

	logic                     out_valid_q;
	status_t                  out_status_q;
	logic        [TIME_W-1:0] out_time_q;
	logic signed [PRIO_W-1:0] out_prio_q;
	logic        [ACT_W-1:0]  out_act_q;
	logic        [PAY_W-1:0]  out_pay_q;

	// control decoded by the output block
	logic          idx_ld;
	logic [AW-1:0] idx_d;
	logic          cnt_inc, cnt_dec, cnt_clr;
	logic          found_clr, found_set;
	logic          sts_ld;
	status_t       sts_d;
	logic          out_ld;

	logic [63:0] pay_in_ext;
	logic [63:0] head_pay_ext;
	logic [EW-1:0] new_entry;

	logic        [TIME_W-1:0] rd_time;
	logic signed [PRIO_W-1:0] rd_prio;
	logic        [ACT_W-1:0]  rd_act;
	logic        [TIME_W-1:0] head_time;
	logic signed [PRIO_W-1:0] head_prio;
	logic        [ACT_W-1:0]  head_act;

	cmp_res_t cmp;

	logic full, past, empty, last_idx, rem_match, found_now, can_out, deliver;

	assign pay_in_ext   = 64'(in_payload);
	assign new_entry    = {pay_in_q, act_in_q, prio_in_q, time_in_q};

	assign rd_time   = mem_rd_data[TIME_W-1:0];
	assign rd_prio   = $signed(mem_rd_data[TIME_W +: PRIO_W]);
	assign rd_act    = mem_rd_data[TIME_W+PRIO_W +: ACT_W];
	assign head_time = head_q[TIME_W-1:0];
	assign head_prio = $signed(head_q[TIME_W +: PRIO_W]);
	assign head_act  = head_q[TIME_W+PRIO_W +: ACT_W];
	assign head_pay_ext = 64'(head_q[EW-1 -: PAYLOAD_BITS]);

	tepq_cmp u_cmp (
		.ent_time (rd_time),
		.ent_prio (rd_prio),
		.ent_act  (rd_act),
		.key_time (time_in_q),
		.key_prio (prio_in_q),
		.key_act  (act_in_q),
		.res      (cmp)
	);

	assign full      = count_q == CW'(DEPTH);
	assign past      = time_in_q < cur_time_q;
	assign empty     = count_q == '0;
	assign last_idx  = (CW'(idx_q) + CW'(1)) == count_q;
	assign rem_match = (op_q == OP_POP) ? (idx_q == '0) : cmp.act_match;
	assign found_now = found_q | rem_match;
	assign can_out   = !out_valid_q || out_ready;
	// a pop that found its head delivers it unless it lies past the limit
	assign deliver   = (op_q == OP_POP) && (sts_q == STS_OK) && (head_time <= time_limit);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_START;
			end
			S_START: begin
				unique case (op_q)
					OP_PUSH: begin
						if (full || past) state_d = S_FIN;
						else if (empty) state_d = S_PUSH_INS;
						else state_d = S_PUSH_SCAN;
					end
					OP_POP, OP_DELETE: begin
						state_d = empty ? S_FIN : S_REM;
					end
					OP_CLEAR: state_d = S_FIN;
					default: state_d = S_FIN;
				endcase
			end
			S_PUSH_SCAN: begin
				if (cmp.ahead) state_d = S_FIN;
				else if (idx_q == '0) state_d = S_PUSH_INS;
			end
			S_PUSH_INS: state_d = S_FIN;
			S_REM: begin
				if (last_idx) state_d = S_FIN;
			end
			S_FIN: begin
				if (can_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready    = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = idx_q;
		mem_wr_data = new_entry;
		mem_rd_addr = idx_q;
		idx_ld      = 1'b0;
		idx_d       = idx_q;
		cnt_inc     = 1'b0;
		cnt_dec     = 1'b0;
		cnt_clr     = 1'b0;
		found_clr   = 1'b0;
		found_set   = 1'b0;
		sts_ld      = 1'b0;
		sts_d       = sts_q;
		out_ld      = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_START: begin
				sts_ld = 1'b1;
				unique case (op_q)
					OP_PUSH: begin
						if (full) sts_d = STS_FULL;
						else if (past) sts_d = STS_PAST;
						else sts_d = STS_OK;
						// scan from the tail toward the head
						idx_ld      = 1'b1;
						idx_d       = empty ? '0 : AW'(count_q - CW'(1));
						mem_rd_addr = idx_d;
					end
					OP_POP: begin
						sts_d       = empty ? STS_EMPTY : STS_OK;
						idx_ld      = 1'b1;
						idx_d       = '0;
						mem_rd_addr = '0;
						found_clr   = 1'b1;
					end
					OP_DELETE: begin
						sts_d       = STS_NOT_FOUND;
						idx_ld      = 1'b1;
						idx_d       = '0;
						mem_rd_addr = '0;
						found_clr   = 1'b1;
					end
					OP_CLEAR: begin
						sts_d   = STS_OK;
						cnt_clr = 1'b1;
					end
					default: sts_d = STS_OK;
				endcase
			end
			S_PUSH_SCAN: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = idx_q + AW'(1);
				if (cmp.ahead) begin
					mem_wr_data = new_entry;
					cnt_inc     = 1'b1;
				end else begin
					// move the entry one slot up, read the next one down
					mem_wr_data = mem_rd_data;
					if (idx_q != '0) begin
						idx_ld      = 1'b1;
						idx_d       = idx_q - AW'(1);
						mem_rd_addr = idx_d;
					end
				end
			end
			S_PUSH_INS: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = idx_q;
				mem_wr_data = new_entry;
				cnt_inc     = 1'b1;
			end
			S_REM: begin
				if (found_q) begin
					// close the gap behind the removed entry
					mem_wr_en   = 1'b1;
					mem_wr_addr = idx_q - AW'(1);
					mem_wr_data = mem_rd_data;
				end else if (rem_match) begin
					found_set = 1'b1;
					sts_ld    = 1'b1;
					sts_d     = STS_OK;
				end
				if (last_idx) begin
					cnt_dec = found_now;
				end else begin
					idx_ld      = 1'b1;
					idx_d       = idx_q + AW'(1);
					mem_rd_addr = idx_d;
				end
			end
			S_FIN: out_ld = can_out;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			cur_time_q  <= '0;
			found_q     <= 1'b0;
			sts_q       <= STS_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (idx_ld) idx_q <= idx_d;
			if (cnt_clr) count_q <= '0;
			else if (cnt_inc) count_q <= count_q + CW'(1);
			else if (cnt_dec) count_q <= count_q - CW'(1);
			if (found_clr) found_q <= 1'b0;
			else if (found_set) found_q <= 1'b1;
			if (sts_ld) sts_q <= sts_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
				if (deliver) cur_time_q <= head_time;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q      <= in_op;
			time_in_q <= in_time;
			prio_in_q <= in_prio;
			act_in_q  <= in_act;
			pay_in_q  <= pay_in_ext[PAYLOAD_BITS-1:0];
		end
		if (found_set) head_q <= mem_rd_data;
		if (out_ld) begin
			if (deliver) begin
				out_status_q <= STS_OK;
				out_time_q   <= head_time;
				out_prio_q   <= head_prio;
				out_act_q    <= head_act;
				out_pay_q    <= head_pay_ext[PAY_W-1:0];
			end else begin
				out_status_q <= (op_q == OP_POP && sts_q == STS_OK) ? STS_LIMIT : sts_q;
				out_time_q   <= '0;
				out_prio_q   <= '0;
				out_act_q    <= '0;
				out_pay_q    <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_time    = out_time_q;
	assign out_prio    = out_prio_q;
	assign out_act     = out_act_q;
	assign out_payload = out_pay_q;

endmodule

// ----- rtl/core/timed_event_priority_queue.sv -----
// Top level of the timed event priority queue: register port, stream packing, store.
//
//  channel  | direction | transfer when                     | carries
//  s_*      | in        | s_tvalid & s_tready               | op, time, priority, action, payload
//  m_*      | out       | m_tvalid & m_tready               | status, time, priority, action, payload
//  APB      | in/out    | psel & penable & pwrite & pready  | time_limit at byte address 0
//
// The time per item is set by the walk through the store, one entry per cycle over its
// single read and write port. s_tready is high only while the sequencer idles; a result
// waiting in the output register does not block the next item until that item finishes.
// Reset empties the queue, zeroes the current time and sets time_limit to all ones.
module timed_event_priority_queue
	import tepq_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,  // event_time, event_priority, action_code, payload
	input  logic [OP_W-1:0]       s_tuser,  // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,  // out_time, out_priority, out_action, out_payload
	output logic [STS_W-1:0]      m_tuser   // status
);

	localparam int AW = $clog2(DEPTH);
	localparam int EW = TIME_W + PRIO_W + ACT_W + PAYLOAD_BITS;

	logic [TIME_W-1:0] time_limit_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic cfg_wr;

	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [EW-1:0] mem_wr_data;
	logic [AW-1:0] mem_rd_addr;
	logic [EW-1:0] mem_rd_data;

	status_t                  out_status;
	logic        [TIME_W-1:0] out_time;
	logic signed [PRIO_W-1:0] out_prio;
	logic        [ACT_W-1:0]  out_act;
	logic        [PAY_W-1:0]  out_payload;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_limit_q <= '1;
		end else if (cfg_wr && reg_idx == REG_TIME_LIMIT) begin
			time_limit_q <= pwdata[TIME_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TIME_LIMIT: prdata = APB_DATA_W'(time_limit_q);
			default:        prdata = '0;
		endcase
	end

	tepq_mem #(
		.DEPTH (DEPTH),
		.WIDTH (EW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	tepq_ctrl #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_op       (op_t'(s_tuser)),
		.in_time     (s_tdata[TIME_W-1:0]),
		.in_prio     ($signed(s_tdata[TIME_W +: PRIO_W])),
		.in_act      (s_tdata[TIME_W+PRIO_W +: ACT_W]),
		.in_payload  (s_tdata[TIME_W+PRIO_W+ACT_W +: PAY_W]),
		.time_limit  (time_limit_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (out_status),
		.out_time    (out_time),
		.out_prio    (out_prio),
		.out_act     (out_act),
		.out_payload (out_payload),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	assign m_tdata = M_DATA_W'({out_payload, out_act, out_prio, out_time});
	assign m_tuser = out_status;

endmodule

// ----- rtl/core/tepq_checker.sv -----
// Port-level checks for the timed event priority queue, bound to the top level.
`include "assert_macros.svh"

module tepq_checker
	import tepq_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [STS_W-1:0]    m_tuser
);

	`TEPQ_ASSERT(a_busy_after_in, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready, "item taken while busy")

	`TEPQ_ASSERT_HOLD(a_out_hold, clk, arst_n, m_tvalid, m_tready, m_tdata, "stalled result changed")

	`TEPQ_ASSERT(a_zero_data, clk, arst_n, (m_tvalid && (m_tuser != STS_OK)) |-> (m_tdata == '0), "data on a failed result")

	`TEPQ_ASSERT(a_sts_range, clk, arst_n, m_tvalid |-> (m_tuser <= STS_NOT_FOUND), "unknown status code")

endmodule

bind timed_event_priority_queue tepq_checker u_tepq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
